[rtl/core/periodic_subcell_corner_indexer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the periodic subcell corner indexer
// Short forms of clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_SUBCELL_CORNER_INDEXER_MACROS_SVH
`define PERIODIC_SUBCELL_CORNER_INDEXER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define PSCI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define PSCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/psci_pkg.sv]
// ----------------------------------------------------------------------------
// psci_pkg
// Shared constants and types of the periodic subcell corner indexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psci_pkg;

  // Field widths
  localparam int unsigned IDX_W       = 24;  // linear point index
  localparam int unsigned CFG_W       = 9;   // configuration write data
  localparam int unsigned CFG_IDX_W   = 2;   // configuration register index
  localparam int unsigned CORNER_W    = 3;   // corner number

  // Default largest grid dimension
  localparam int unsigned MAX_DIM_DEF = 256;

  // Quotient bits resolved per divider cycle
  localparam int unsigned Q_BITS      = 3;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Cycles for the dimension products to settle after a register write
  localparam int unsigned SETTLE_CYC  = 2;
  localparam int unsigned SETTLE_W    = 2;

  // Last corner of a subcell
  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_FIRST  = 2'd0,
    REG_DIM_SECOND = 2'd1,
    REG_DIM_THIRD  = 2'd2
  } psci_reg_e;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } psci_qstat_t;

endpackage

[rtl/core/psci_queue.sv]
// ----------------------------------------------------------------------------
// psci_queue
// Short first-in first-out queue that decouples the decoder from the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psci_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = psci_pkg::QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [Width-1:0]          push_data_i,
  input  logic                      pop_i,
  output logic [Width-1:0]          pop_data_o,
  output psci_pkg::psci_qstat_t     stat_o
);
  import psci_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

[rtl/core/psci_front.sv]
// ----------------------------------------------------------------------------
// psci_front
// Accepts an item, checks it against the grid size and decodes the linear
// index into axis coordinates with a shared radix-8 restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psci_front #(
  parameter int unsigned DimW = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [psci_pkg::IDX_W-1:0] point_index_i,
  input  logic [2*DimW-1:0]          plane_i,
  input  logic [3*DimW-1:0]          total_i,
  input  logic [DimW-1:0]            dim_second_i,
  input  psci_pkg::psci_qstat_t      q_stat_i,
  output logic                       push_o,
  output logic [3*DimW:0]            push_data_o,
  output logic                       busy_o
);
  import psci_pkg::*;

  localparam int unsigned NumIter = (DimW + Q_BITS - 1) / Q_BITS;
  localparam int unsigned QW      = NumIter * Q_BITS;
  localparam int unsigned DW      = (IDX_W > 2 * DimW + QW) ? IDX_W : 2 * DimW + QW;
  localparam int unsigned TW      = 3 * DimW;
  localparam int unsigned CW      = (IDX_W > TW) ? IDX_W : TW;
  localparam int unsigned IterW   = (NumIter > 1) ? $clog2(NumIter) : 1;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV_C,
    FE_DIV_A,
    FE_ERR
  } fe_state_e;

  fe_state_e        state_q;
  logic [IterW-1:0] iter_q;
  logic [DW-1:0]    rem_q, dsh_q;
  logic [QW-1:0]    quo_q;
  logic [DimW-1:0]  c_q;

  logic [DW-1:0]    rem_step, dsh_step;
  logic [QW-1:0]    quo_step;
  logic             is_last;
  logic             idx_err;

  // Out-of-grid test on the incoming index
  assign idx_err = (total_i == '0) || (CW'(point_index_i) >= CW'(total_i));
  assign is_last = (iter_q == IterW'(NumIter - 1));

  // One divider cycle: Q_BITS compare-subtract steps
  always_comb begin
    logic [DW-1:0] r;
    logic [DW-1:0] d;
    logic [QW-1:0] q;
    r = rem_q;
    d = dsh_q;
    q = quo_q;
    for (int j = 0; j < Q_BITS; j++) begin
      if (r >= d) begin
        r = r - d;
        q = {q[QW-2:0], 1'b1};
      end else begin
        q = {q[QW-2:0], 1'b0};
      end
      d = d >> 1;
    end
    rem_step = r;
    dsh_step = d;
    quo_step = q;
  end

  // Queue write: decoded point {err, c, b, a} or an error marker
  assign push_o = ((state_q == FE_DIV_A && is_last) || state_q == FE_ERR) && !q_stat_i.full;
  always_comb begin
    if (state_q == FE_ERR) begin
      push_data_o = {1'b1, {(3 * DimW){1'b0}}};
    end else begin
      push_data_o = {1'b0, c_q, rem_step[DimW-1:0], quo_step[DimW-1:0]};
    end
  end

  assign busy_o = (state_q != FE_IDLE);

  // Sequencer and divider registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      iter_q  <= '0;
      rem_q   <= '0;
      dsh_q   <= '0;
      quo_q   <= '0;
      c_q     <= '0;
    end else begin
      unique case (state_q)
        FE_IDLE: begin
          if (accept_i) begin
            rem_q   <= DW'(point_index_i);
            dsh_q   <= DW'(plane_i) << (QW - 1);
            quo_q   <= '0;
            iter_q  <= '0;
            state_q <= idx_err ? FE_ERR : FE_DIV_C;
          end
        end
        // third-axis coordinate: index / plane
        FE_DIV_C: begin
          rem_q <= rem_step;
          if (is_last) begin
            c_q     <= quo_step[DimW-1:0];
            dsh_q   <= DW'(dim_second_i) << (QW - 1);
            quo_q   <= '0;
            iter_q  <= '0;
            state_q <= FE_DIV_A;
          end else begin
            dsh_q  <= dsh_step;
            quo_q  <= quo_step;
            iter_q <= iter_q + 1'b1;
          end
        end
        // first and second axis: remainder / dim_second
        FE_DIV_A: begin
          if (!is_last) begin
            rem_q  <= rem_step;
            dsh_q  <= dsh_step;
            quo_q  <= quo_step;
            iter_q <= iter_q + 1'b1;
          end else if (!q_stat_i.full) begin
            state_q <= FE_IDLE;
          end
        end
        FE_ERR: begin
          if (!q_stat_i.full) begin
            state_q <= FE_IDLE;
          end
        end
        default: state_q <= FE_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/psci_back.sv]
// ----------------------------------------------------------------------------
// psci_back
// Takes decoded points from the queue, forms the wrapped axis terms and
// emits the eight corner indices, one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psci_back #(
  parameter int unsigned DimW = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [DimW-1:0]               dim_first_i,
  input  logic [DimW-1:0]               dim_second_i,
  input  logic [DimW-1:0]               dim_third_i,
  input  logic [2*DimW-1:0]             plane_i,
  input  psci_pkg::psci_qstat_t         q_stat_i,
  input  logic [3*DimW:0]               q_data_i,
  output logic                          pop_o,
  output logic                          res_valid_o,
  output logic [psci_pkg::IDX_W-1:0]    corner_index_o,
  output logic [psci_pkg::CORNER_W-1:0] corner_number_o,
  output logic                          last_corner_o,
  output logic                          index_error_o
);
  import psci_pkg::*;

  localparam int unsigned PW = (3 * DimW > IDX_W) ? 3 * DimW : IDX_W;

  // Queue head
  logic            h_err;
  logic [DimW-1:0] h_a, h_b, h_c;
  logic [DimW:0]   a_inc, b_inc, c_inc;
  logic [DimW-1:0] na, nb, nc;
  logic [PW-1:0]   prod_c0, prod_c1;

  // Term stage
  logic              t_vld_q, t_err_q;
  logic [2*DimW-1:0] t_a_q [2];
  logic [DimW-1:0]   t_b_q [2];
  logic [IDX_W-1:0]  t_c_q [2];

  // Emission stage
  logic              e_vld_q, e_err_q;
  logic [CORNER_W-1:0] k_q;
  logic [2*DimW-1:0] e_a_q [2];
  logic [DimW-1:0]   e_b_q [2];
  logic [IDX_W-1:0]  e_c_q [2];

  // Result register
  logic                res_valid_q, last_q, err_q;
  logic [IDX_W-1:0]    corner_q;
  logic [CORNER_W-1:0] num_q;

  logic             e_done, load_e;
  logic [IDX_W-1:0] corner_sum;

  assign {h_err, h_c, h_b, h_a} = q_data_i;

  // Periodic +1 step on each axis
  assign a_inc = {1'b0, h_a} + 1'b1;
  assign b_inc = {1'b0, h_b} + 1'b1;
  assign c_inc = {1'b0, h_c} + 1'b1;
  assign na    = (a_inc >= {1'b0, dim_first_i})  ? '0 : a_inc[DimW-1:0];
  assign nb    = (b_inc >= {1'b0, dim_second_i}) ? '0 : b_inc[DimW-1:0];
  assign nc    = (c_inc >= {1'b0, dim_third_i})  ? '0 : c_inc[DimW-1:0];

  assign prod_c0 = PW'(plane_i) * PW'(h_c);
  assign prod_c1 = PW'(plane_i) * PW'(nc);

  // Stage handshakes
  assign e_done = e_vld_q && (e_err_q || k_q == LAST_CORNER);
  assign load_e = t_vld_q && (!e_vld_q || e_done);
  assign pop_o  = !q_stat_i.empty && (!t_vld_q || load_e);

  // Corner index: first-axis term + second-axis term + third-axis term
  assign corner_sum = IDX_W'(e_a_q[k_q[0]]) + IDX_W'(e_b_q[k_q[1]]) + e_c_q[k_q[2]];

  // Term, emission and result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      t_err_q  <= h_err;
      t_a_q[0] <= (2 * DimW)'(dim_second_i) * (2 * DimW)'(h_a);
      t_a_q[1] <= (2 * DimW)'(dim_second_i) * (2 * DimW)'(na);
      t_b_q[0] <= h_b;
      t_b_q[1] <= nb;
      t_c_q[0] <= prod_c0[IDX_W-1:0];
      t_c_q[1] <= prod_c1[IDX_W-1:0];
    end
    if (load_e) begin
      e_err_q <= t_err_q;
      e_a_q   <= t_a_q;
      e_b_q   <= t_b_q;
      e_c_q   <= t_c_q;
    end
    if (e_vld_q) begin
      corner_q <= e_err_q ? '0 : corner_sum;
      num_q    <= e_err_q ? '0 : k_q;
      last_q   <= e_done;
      err_q    <= e_err_q;
    end
  end

  // Stage valids and corner counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q     <= 1'b0;
      e_vld_q     <= 1'b0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        t_vld_q <= 1'b1;
      end else if (load_e) begin
        t_vld_q <= 1'b0;
      end
      if (load_e) begin
        e_vld_q <= 1'b1;
        k_q     <= '0;
      end else if (e_done) begin
        e_vld_q <= 1'b0;
      end else if (e_vld_q) begin
        k_q <= k_q + 1'b1;
      end
      res_valid_q <= e_vld_q;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign corner_index_o  = corner_q;
  assign corner_number_o = num_q;
  assign last_corner_o   = last_q;
  assign index_error_o   = err_q;

endmodule

[rtl/core/periodic_subcell_corner_indexer.sv]
// ----------------------------------------------------------------------------
// periodic_subcell_corner_indexer
// Decodes a linear grid index and emits the eight wrapped subcell corners.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   config   | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//   item in  | start_i && !busy_o       | point_index_i
//   result   | res_valid_o (one cycle)  | corner_index_o, corner_number_o,
//            |                          | last_corner_o, index_error_o
//
// A valid item yields eight results, one per cycle, so the emitter sets the
// sustained rate. The decoder takes no new item until it has queued the last
// one; an out-of-grid item yields one error result. busy_o is high during a
// register write and after it, while the plane and total products settle.
// Reset clears control only; results cannot be stalled, and a full queue
// holds the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_subcell_corner_indexer_macros.svh"

module periodic_subcell_corner_indexer #(
  parameter int unsigned MaxDim = psci_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psci_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psci_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          start_i,
  input  logic [psci_pkg::IDX_W-1:0]    point_index_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output logic [psci_pkg::IDX_W-1:0]    corner_index_o,
  output logic [psci_pkg::CORNER_W-1:0] corner_number_o,
  output logic                          last_corner_o,
  output logic                          index_error_o
);
  import psci_pkg::*;

  localparam int unsigned CfgMax = (2 ** CFG_W) - 1;
  localparam int unsigned DimCap = (MaxDim < CfgMax) ? MaxDim : CfgMax;
  localparam int unsigned DimW   = $clog2(DimCap + 1);
  localparam int unsigned EntW   = 3 * DimW + 1;

  logic [DimW-1:0]     dim_first_q, dim_second_q, dim_third_q;
  logic [DimW-1:0]     cfg_sat;
  logic [2*DimW-1:0]   plane_q;
  logic [3*DimW-1:0]   total_q;
  logic [SETTLE_W-1:0] settle_q;

  logic                front_busy, accept;
  logic                q_push, q_pop;
  logic [EntW-1:0]     q_push_data, q_pop_data;
  psci_qstat_t         q_stat;

  // Saturate written dimensions to MaxDim
  assign cfg_sat = (32'(cfg_wdata_i) > MaxDim) ? DimW'(MaxDim) : DimW'(cfg_wdata_i);

  // Dimension registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_first_q  <= DimW'(1);
      dim_second_q <= DimW'(1);
      dim_third_q  <= DimW'(1);
    end else if (cfg_we_i) begin
      unique case (psci_reg_e'(cfg_idx_i))
        REG_DIM_FIRST:  dim_first_q  <= cfg_sat;
        REG_DIM_SECOND: dim_second_q <= cfg_sat;
        REG_DIM_THIRD:  dim_third_q  <= cfg_sat;
        default: ;
      endcase
    end
  end

  // Plane and total grid size, one multiply per stage
  always_ff @(posedge clk_i) begin
    plane_q <= (2 * DimW)'(dim_first_q) * (2 * DimW)'(dim_second_q);
    total_q <= (3 * DimW)'(plane_q) * (3 * DimW)'(dim_third_q);
  end

  // Hold off items until the products match the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_W'(SETTLE_CYC);
    end else if (cfg_we_i) begin
      settle_q <= SETTLE_W'(SETTLE_CYC);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  assign busy_o = front_busy || cfg_we_i || (settle_q != '0);
  assign accept = start_i && !busy_o;

  psci_front #(
    .DimW (DimW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .point_index_i (point_index_i),
    .plane_i       (plane_q),
    .total_i       (total_q),
    .dim_second_i  (dim_second_q),
    .q_stat_i      (q_stat),
    .push_o        (q_push),
    .push_data_o   (q_push_data),
    .busy_o        (front_busy)
  );

  psci_queue #(
    .Width (EntW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .stat_o      (q_stat)
  );

  psci_back #(
    .DimW (DimW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dim_first_i     (dim_first_q),
    .dim_second_i    (dim_second_q),
    .dim_third_i     (dim_third_q),
    .plane_i         (plane_q),
    .q_stat_i        (q_stat),
    .q_data_i        (q_pop_data),
    .pop_o           (q_pop),
    .res_valid_o     (res_valid_o),
    .corner_index_o  (corner_index_o),
    .corner_number_o (corner_number_o),
    .last_corner_o   (last_corner_o),
    .index_error_o   (index_error_o)
  );

  // Error results stand alone and carry zero fields
  `PSCI_ASSERT_IMPL(a_err_single, res_valid_o && index_error_o,
                    last_corner_o && corner_index_o == '0 && corner_number_o == '0,
                    "error result not a lone zero result")
  // Corners of one subcell come in consecutive cycles and in order
  `PSCI_ASSERT_NEXT(a_corner_seq, res_valid_o && !last_corner_o,
                    res_valid_o && corner_number_o == $past(corner_number_o) + 3'd1,
                    "corner run broken or out of order")
  // A run of good corners ends on the last corner
  `PSCI_ASSERT_IMPL(a_last_is_seven, res_valid_o && last_corner_o && !index_error_o,
                    corner_number_o == LAST_CORNER,
                    "run ended before the last corner")

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the periodic subcell corner indexer against a built-in predictor of
// the eight wrapped corners. A short directed table covers reset defaults,
// grid extremes, empty grids, saturating dimensions and an unused register.
// Random phases then vary the grid and the sender's idle rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import psci_pkg::*;

  localparam int unsigned CLK_HALF   = 2;
  localparam int unsigned RST_CYC    = 11;
  localparam int unsigned IDLE_TAIL  = 4;       // settle cycles before a register write
  localparam int unsigned END_TAIL   = 20;
  localparam int unsigned END_LIMIT  = 5000;
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned SEG_ITEMS  = 20;
  localparam longint unsigned TIMEOUT_NS = 2_000_000;
  localparam int unsigned IDX_SPAN   = 1 << IDX_W;
  localparam int unsigned DIM_CAP    = MAX_DIM_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum bit {CHK_MODEL, CHK_TYPED} row_chk_e;

  typedef struct packed {
    logic [IDX_W-1:0]    corner_index;
    logic [CORNER_W-1:0] corner_number;
    logic                last_corner;
    logic                index_error;
  } corner_rec_t;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [IDX_W-1:0]     value;
    row_chk_e             chk;
    bit                   t_err;
    logic [IDX_W-1:0]     t_corner;
  } dir_row_t;

  // Directed table; typed rows carry their result, the rest use the predictor
  dir_row_t dir_table [27] = '{
    '{ROW_ITEM, REG_DIM_FIRST,  24'd0,        CHK_TYPED, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd1,        CHK_TYPED, 1'b1, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'hFFFFFF,   CHK_TYPED, 1'b1, 24'd0},
    '{ROW_CFG,  REG_DIM_FIRST,  24'd256,      CHK_MODEL, 1'b0, 24'd0},
    '{ROW_CFG,  REG_DIM_SECOND, 24'd256,      CHK_MODEL, 1'b0, 24'd0},
    '{ROW_CFG,  REG_DIM_THIRD,  24'd256,      CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd0,        CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'hFFFFFF,   CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'h00FF00,   CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'hAAAAAA,   CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'h555555,   CHK_MODEL, 1'b0, 24'd0},
    '{ROW_CFG,  REG_DIM_SECOND, 24'd0,        CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd0,        CHK_TYPED, 1'b1, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd5,        CHK_TYPED, 1'b1, 24'd0},
    '{ROW_CFG,  REG_DIM_SECOND, 24'd511,      CHK_MODEL, 1'b0, 24'd0},
    '{ROW_CFG,  REG_DIM_FIRST,  24'd3,        CHK_MODEL, 1'b0, 24'd0},
    '{ROW_CFG,  REG_DIM_THIRD,  24'd2,        CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd0,        CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd1535,     CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd1536,     CHK_TYPED, 1'b1, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd767,      CHK_MODEL, 1'b0, 24'd0},
    '{ROW_CFG,  REG_UNUSED,     24'd5,        CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd1535,     CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd1536,     CHK_TYPED, 1'b1, 24'd0},
    '{ROW_CFG,  REG_DIM_FIRST,  24'd1,        CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd255,      CHK_MODEL, 1'b0, 24'd0},
    '{ROW_ITEM, REG_DIM_FIRST,  24'd511,      CHK_MODEL, 1'b0, 24'd0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 start_i = 1'b0;
  logic [IDX_W-1:0]     point_index_i = '0;
  logic                 busy_o;
  logic                 res_valid_o;
  logic [IDX_W-1:0]     corner_index_o;
  logic [CORNER_W-1:0]  corner_number_o;
  logic                 last_corner_o;
  logic                 index_error_o;

  // Predictor state: grid dimensions as the block should hold them
  int unsigned grid_first  = 1;
  int unsigned grid_second = 1;
  int unsigned grid_third  = 1;

  corner_rec_t corner_q [$];
  int unsigned fail_count = 0;
  int unsigned gap_pct    = 6;

  periodic_subcell_corner_indexer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (start_i),
    .point_index_i   (point_index_i),
    .busy_o          (busy_o),
    .res_valid_o     (res_valid_o),
    .corner_index_o  (corner_index_o),
    .corner_number_o (corner_number_o),
    .last_corner_o   (last_corner_o),
    .index_error_o   (index_error_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Append one expected corner to the tail of the queue
  function automatic void note_corner(input corner_rec_t rec);
    corner_q = {corner_q, rec};
  endfunction

  // Expected corners of one item under the current grid
  function automatic void predict_corners(input logic [IDX_W-1:0] idx);
    int unsigned plane, total, rem, a, b, c, na, nb, nc, lin;
    corner_rec_t rec;
    plane = grid_first * grid_second;
    total = plane * grid_third;
    if (total == 0 || idx >= total) begin
      rec = '{corner_index: '0, corner_number: '0, last_corner: 1'b1, index_error: 1'b1};
      note_corner(rec);
      return;
    end
    c   = idx / plane;
    rem = idx % plane;
    a   = rem / grid_second;
    b   = rem % grid_second;
    for (int k = 0; k < 8; k++) begin
      na  = (a + k[0] >= grid_first)  ? 0 : a + k[0];
      nb  = (b + k[1] >= grid_second) ? 0 : b + k[1];
      nc  = (c + k[2] >= grid_third)  ? 0 : c + k[2];
      lin = grid_second * na + nb + plane * nc;
      rec.corner_index  = lin[IDX_W-1:0];
      rec.corner_number = k[CORNER_W-1:0];
      rec.last_corner   = (k[CORNER_W-1:0] == LAST_CORNER);
      rec.index_error   = 1'b0;
      note_corner(rec);
    end
  endfunction

  // Hand-written result of a table row: an error, or eight equal corners
  function automatic void push_typed(input bit err, input logic [IDX_W-1:0] corner);
    corner_rec_t rec;
    if (err) begin
      rec = '{corner_index: '0, corner_number: '0, last_corner: 1'b1, index_error: 1'b1};
      note_corner(rec);
    end else begin
      for (int k = 0; k < 8; k++) begin
        rec.corner_index  = corner;
        rec.corner_number = k[CORNER_W-1:0];
        rec.last_corner   = (k[CORNER_W-1:0] == LAST_CORNER);
        rec.index_error   = 1'b0;
        note_corner(rec);
      end
    end
  endfunction

  function automatic int unsigned pick_coord(input int unsigned dim);
    int unsigned roll;
    roll = $urandom_range(3);
    if (roll == 0) return 0;
    if (roll == 1) return dim - 1;
    return $urandom_range(dim - 1, 0);
  endfunction

  // Mostly in-grid points with edges favored, the rest anywhere or past the end
  function automatic logic [IDX_W-1:0] random_point();
    int unsigned plane, total, roll, lin;
    plane = grid_first * grid_second;
    total = plane * grid_third;
    roll  = $urandom_range(99);
    if (total != 0 && roll < 80) begin
      lin = grid_second * pick_coord(grid_first) + pick_coord(grid_second)
            + plane * pick_coord(grid_third);
      return lin[IDX_W-1:0];
    end
    if (roll < 90 || total >= IDX_SPAN) return IDX_W'($urandom);
    return IDX_W'($urandom_range(IDX_SPAN - 1, total));
  endfunction

  // Raw register value for one segment of the random part
  function automatic logic [CFG_W-1:0] random_dim(input int unsigned seg);
    int unsigned roll;
    roll = $urandom_range(9);
    case (seg)
      0: return CFG_W'($urandom_range(8, 1));
      1: return CFG_W'($urandom_range(256, 1));
      2: return (roll == 0) ? 9'd511 : 9'd256;
      3: return (roll < 5) ? 9'd1 : CFG_W'($urandom_range(256, 1));
      4: begin
        if (roll == 0) return 9'd0;
        if (roll == 1) return CFG_W'($urandom_range(511, 257));
        return CFG_W'($urandom_range(256, 1));
      end
      default: return CFG_W'($urandom_range(4, 1));
    endcase
  endfunction

  // Register write; caller is at a falling edge with the block idle
  task automatic write_dim(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
    int unsigned v;
    v = (val > DIM_CAP) ? DIM_CAP : val;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      REG_DIM_FIRST:  grid_first  = v;
      REG_DIM_SECOND: grid_second = v;
      REG_DIM_THIRD:  grid_third  = v;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Hold off until every expected corner is back
  task automatic drain_results();
    start_i <= 1'b0;
    while (corner_q.size() != 0) @(negedge clk_i);
    repeat (IDLE_TAIL) @(negedge clk_i);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Present one item; start stays high on return at the next falling edge
  task automatic send_point(input logic [IDX_W-1:0] idx, input row_chk_e chk,
                            input bit t_err, input logic [IDX_W-1:0] t_corner);
    start_i       <= 1'b1;
    point_index_i <= idx;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    if (chk == CHK_TYPED) push_typed(t_err, t_corner);
    else predict_corners(idx);
    @(negedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    corner_rec_t want;
    if (rst_ni && res_valid_o) begin
      if (corner_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected corner: idx=%0d num=%0d last=%0b err=%0b",
                   corner_index_o, corner_number_o, last_corner_o, index_error_o);
      end else begin
        want = corner_q.pop_front();
        if (corner_index_o !== want.corner_index || corner_number_o !== want.corner_number ||
            last_corner_o !== want.last_corner || index_error_o !== want.index_error) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("corner mismatch: exp idx=%0d num=%0d last=%0b err=%0b,",
                     want.corner_index, want.corner_number, want.last_corner,
                     want.index_error,
                     " got idx=%0d num=%0d last=%0b err=%0b",
                     corner_index_o, corner_number_o, last_corner_o, index_error_o);
        end
      end
    end
  end

  // Stimulus
  initial begin
    repeat (RST_CYC) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain_results();
        write_dim(dir_table[i].reg_sel, dir_table[i].value[CFG_W-1:0]);
      end else begin
        sender_gap();
        send_point(dir_table[i].value, dir_table[i].chk, dir_table[i].t_err,
                   dir_table[i].t_corner);
      end
    end

    // Random phases: light sender idling, heavy idling, none
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 6 : (ph == 1) ? 57 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        drain_results();
        write_dim(REG_DIM_FIRST,  random_dim(seg));
        write_dim(REG_DIM_SECOND, random_dim(seg));
        write_dim(REG_DIM_THIRD,  random_dim(seg));
        for (int n = 0; n < SEG_ITEMS; n++) begin
          sender_gap();
          send_point(random_point(), CHK_MODEL, 1'b0, '0);
          if ($urandom_range(29) == 0) drain_results();
        end
      end
    end
    start_i <= 1'b0;

    // Wait out the remaining corners, then a short tail
    for (int w = 0; w < END_LIMIT && corner_q.size() != 0; w++) @(posedge clk_i);
    repeat (END_TAIL) @(posedge clk_i);
    if (fail_count == 0 && corner_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
